// File: rtl/piecewise_linear_bracket_lookup_macros.svh
// Assertion macros for the piecewise-linear bracket lookup.
`ifndef PIECEWISE_LINEAR_BRACKET_LOOKUP_MACROS_SVH
`define PIECEWISE_LINEAR_BRACKET_LOOKUP_MACROS_SVH

`ifndef SYNTHESIS
`define PWLB_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PWLB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PWLB_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define PWLB_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: rtl/pwlb_pkg.sv
package pwlb_pkg;

    localparam int MAX_POINTS = 16;
    localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int POS_W      = 24;
    localparam int ID_W       = 16;
    localparam int ALPHA_W    = 17;
    localparam int FRAC_W     = 16;
    localparam int STEP_W     = $clog2(ALPHA_W + 1);
    localparam int REG_IDX_W  = 1;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1) << FRAC_W;
    localparam logic [POS_W-1:0]   AXIS_MAX_RST = POS_W'(1) << FRAC_W;

    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_EVAL = 1'b1;

    localparam logic [REG_IDX_W-1:0] REG_AXIS_MIN = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_AXIS_MAX = REG_IDX_W'(1);

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NULL  = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SRCH,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic signed [POS_W-1:0] pos;
        logic [ID_W-1:0]         id;
    } t_point;

    // handoff from a cell to its right neighbor
    typedef struct packed {
        t_point pt;
        logic   gt;
    } t_link;

    typedef struct packed {
        logic   ins;
        t_point pt;
    } t_ins_req;

endpackage

// File: rtl/pwlb_if.sv
interface pwlb_req_if;
    logic                                valid;
    logic                                ready;
    logic                                kind;
    logic [pwlb_pkg::ID_W-1:0]           anim_id;
    logic signed [pwlb_pkg::POS_W-1:0]   sample_position;
    logic signed [pwlb_pkg::POS_W-1:0]   axis_value;

    modport source (output valid, kind, anim_id, sample_position, axis_value, input ready);
    modport sink   (input valid, kind, anim_id, sample_position, axis_value, output ready);
endinterface

interface pwlb_rsp_if;
    logic                         valid;
    logic                         ready;
    pwlb_pkg::t_status            status;
    logic [pwlb_pkg::ID_W-1:0]    first_id;
    logic [pwlb_pkg::ID_W-1:0]    second_id;
    logic [pwlb_pkg::ALPHA_W-1:0] alpha;

    modport source (output valid, status, first_id, second_id, alpha, input ready);
    modport sink   (input valid, status, first_id, second_id, alpha, output ready);
endinterface

interface pwlb_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [pwlb_pkg::REG_IDX_W-1:0] reg_index;
    logic [pwlb_pkg::POS_W-1:0]     wdata;

    modport source (output valid, reg_index, wdata, input ready);
    modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// File: rtl/pwlb_cell.sv
module pwlb_cell (
    input  logic                          i_clk,
    input  pwlb_pkg::t_ins_req            i_ins,
    input  pwlb_pkg::t_link               i_prev,
    input  logic                          i_occ,
    input  logic signed [pwlb_pkg::POS_W-1:0] i_x,
    output pwlb_pkg::t_link               o_link,
    output logic                          o_ge
);

    pwlb_pkg::t_point r_pt;
    logic             w_gt;

    // empty cells count as greater so the new point lands at the tail
    assign w_gt = !i_occ || ($signed(r_pt.pos) > $signed(i_ins.pt.pos));

    always_ff @(posedge i_clk) begin
        if (i_ins.ins && w_gt) begin
            r_pt <= i_prev.gt ? i_prev.pt : i_ins.pt;
        end
    end

    assign o_link.pt = r_pt;
    assign o_link.gt = w_gt;
    assign o_ge      = $signed(r_pt.pos) >= $signed(i_x);

endmodule

// File: rtl/pwlb_chain.sv
module pwlb_chain (
    input  logic                              i_clk,
    input  pwlb_pkg::t_ins_req                i_ins,
    input  logic [pwlb_pkg::CNT_W-1:0]        i_count,
    input  logic signed [pwlb_pkg::POS_W-1:0] i_x,
    output pwlb_pkg::t_point                  o_pts [pwlb_pkg::MAX_POINTS],
    output logic [pwlb_pkg::MAX_POINTS-1:0]   o_ge
);

    pwlb_pkg::t_link w_link [pwlb_pkg::MAX_POINTS];

    for (genvar g = 0; g < pwlb_pkg::MAX_POINTS; g++) begin : g_cell
        pwlb_pkg::t_link w_prev;
        logic            w_occ;

        if (g == 0) begin : g_head
            assign w_prev = '0;
        end else begin : g_body
            assign w_prev = w_link[g-1];
        end

        assign w_occ = pwlb_pkg::CNT_W'(g) < i_count;

        pwlb_cell u_cell (
            .i_clk  (i_clk),
            .i_ins  (i_ins),
            .i_prev (w_prev),
            .i_occ  (w_occ),
            .i_x    (i_x),
            .o_link (w_link[g]),
            .o_ge   (o_ge[g])
        );

        assign o_pts[g] = w_link[g].pt;
    end

endmodule

// File: rtl/pwlb_div.sv
`include "piecewise_linear_bracket_lookup_macros.svh"

module pwlb_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pwlb_pkg::POS_W:0]      i_num,
    input  logic [pwlb_pkg::POS_W:0]      i_den,
    output logic                          o_done,
    output logic [pwlb_pkg::ALPHA_W-1:0]  o_quot
);

    logic                            r_busy;
    logic [pwlb_pkg::STEP_W-1:0]     r_step;
    logic [pwlb_pkg::POS_W+1:0]      r_rem;
    logic [pwlb_pkg::POS_W:0]        r_den;
    logic [pwlb_pkg::ALPHA_W-1:0]    r_quot;
    logic [pwlb_pkg::POS_W+1:0]      w_trial;
    logic                            w_fit;
    logic                            w_last;

    // first step takes the integer bit, the rest shift one bit each
    assign w_trial = (r_step == '0) ? r_rem : {r_rem[pwlb_pkg::POS_W:0], 1'b0};
    assign w_fit   = w_trial >= {1'b0, r_den};
    assign w_last  = r_step == pwlb_pkg::STEP_W'(pwlb_pkg::ALPHA_W);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            if (w_last) begin
                r_busy <= 1'b0;
            end else begin
                r_step <= r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= {1'b0, i_num};
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy && !w_last) begin
            r_rem  <= w_fit ? (w_trial - {1'b0, r_den}) : w_trial;
            r_quot <= {r_quot[pwlb_pkg::ALPHA_W-2:0], w_fit};
        end
    end

    assign o_done = r_busy && w_last;
    assign o_quot = r_quot;

    `PWLB_ASSERT_NOW(a_step_range, i_clk, i_rst_n, r_busy, r_step <= pwlb_pkg::STEP_W'(pwlb_pkg::ALPHA_W))
    `PWLB_ASSERT_NEXT(a_done_clears, i_clk, i_rst_n, o_done && !i_start, !r_busy)
    `PWLB_ASSERT_NOW(a_rem_below, i_clk, i_rst_n, r_busy && (r_step != '0), r_rem < {1'b0, r_den})

endmodule

// File: rtl/piecewise_linear_bracket_lookup.sv
// Path from the accepting edge to a valid result: an add request goes from S_IDLE to S_DONE;
// an evaluate request goes through S_SRCH to S_DONE at an end point or on an empty table,
// and also through S_DIV when a bracketing pair is found (17-step restoring divider for alpha).
// One request at a time: a new request is taken only back in S_IDLE, after S_DONE has loaded
// the result, and later while the previous result waits for o_rsp.ready.
// Reset clears the point count, the control state and sets axis_min 0, axis_max 1.0;
// stored point contents stay undefined.
`include "piecewise_linear_bracket_lookup_macros.svh"

module piecewise_linear_bracket_lookup (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pwlb_req_if.sink   i_req,
    pwlb_rsp_if.source o_rsp,
    pwlb_cfg_if.sink   i_cfg
);

    pwlb_pkg::t_state                 r_state, n_state;
    logic [pwlb_pkg::CNT_W-1:0]       r_count;
    logic signed [pwlb_pkg::POS_W-1:0] r_axis_min, r_axis_max;
    logic signed [pwlb_pkg::POS_W-1:0] r_x;

    pwlb_pkg::t_status                r_st;
    logic [pwlb_pkg::ID_W-1:0]        r_first, r_second;
    logic [pwlb_pkg::ALPHA_W-1:0]     r_alpha;
    logic                             r_zero_span;

    logic                             r_out_valid;
    pwlb_pkg::t_status                r_o_status;
    logic [pwlb_pkg::ID_W-1:0]        r_o_first, r_o_second;
    logic [pwlb_pkg::ALPHA_W-1:0]     r_o_alpha;

    logic                             w_accept;
    logic                             w_is_add;
    logic                             w_full;
    logic                             w_in_ready;
    logic                             w_out_load;
    logic                             w_div_start;
    logic                             w_div_done;
    logic [pwlb_pkg::ALPHA_W-1:0]     w_quot;
    pwlb_pkg::t_ins_req               w_ins;
    logic signed [pwlb_pkg::POS_W-1:0] w_clamp;

    pwlb_pkg::t_point                 w_pts [pwlb_pkg::MAX_POINTS];
    logic [pwlb_pkg::MAX_POINTS-1:0]  w_ge;
    logic [pwlb_pkg::IDX_W-1:0]       w_last_idx;
    logic [pwlb_pkg::IDX_W-1:0]       w_sel;
    logic [pwlb_pkg::IDX_W-1:0]       w_sel_lo;
    logic                             w_empty;
    logic                             w_at_first;
    logic                             w_at_last;
    logic                             w_pair;
    pwlb_pkg::t_point                 w_a, w_b, w_first_pt, w_last_pt;
    logic [pwlb_pkg::POS_W:0]         w_num, w_span;

    assign w_accept = i_req.valid && w_in_ready;
    assign w_is_add = i_req.kind == pwlb_pkg::KIND_ADD;
    assign w_full   = r_count >= pwlb_pkg::CNT_W'(pwlb_pkg::MAX_POINTS);

    assign w_ins.ins    = w_accept && w_is_add && (i_req.anim_id != '0) && !w_full;
    assign w_ins.pt.pos = i_req.sample_position;
    assign w_ins.pt.id  = i_req.anim_id;

    assign w_clamp = ($signed(i_req.axis_value) < r_axis_min) ? r_axis_min :
                     (($signed(i_req.axis_value) < r_axis_max) ? i_req.axis_value : r_axis_max);

    pwlb_chain u_chain (
        .i_clk   (i_clk),
        .i_ins   (w_ins),
        .i_count (r_count),
        .i_x     (r_x),
        .o_pts   (w_pts),
        .o_ge    (w_ge)
    );

    // search: first point at or above x, among points 1..count-1
    always_comb begin
        w_sel = '0;
        for (int j = pwlb_pkg::MAX_POINTS - 1; j >= 1; j--) begin
            if (w_ge[j] && (pwlb_pkg::CNT_W'(j) < r_count)) begin
                w_sel = pwlb_pkg::IDX_W'(j);
            end
        end
    end

    assign w_last_idx = pwlb_pkg::IDX_W'(r_count - 1'b1);
    assign w_sel_lo   = w_sel - 1'b1;
    assign w_first_pt = w_pts[0];
    assign w_last_pt  = w_pts[w_last_idx];
    assign w_a        = w_pts[w_sel_lo];
    assign w_b        = w_pts[w_sel];

    assign w_empty    = r_count == '0;
    assign w_at_first = (r_x <= $signed(w_first_pt.pos)) ||
                        (r_count == pwlb_pkg::CNT_W'(1));
    assign w_at_last  = r_x >= $signed(w_last_pt.pos);
    assign w_pair     = !w_empty && !w_at_first && !w_at_last;

    assign w_num  = {r_x[pwlb_pkg::POS_W-1], r_x} - {w_a.pos[pwlb_pkg::POS_W-1], w_a.pos};
    assign w_span = {w_b.pos[pwlb_pkg::POS_W-1], w_b.pos} -
                    {w_a.pos[pwlb_pkg::POS_W-1], w_a.pos};

    pwlb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_span),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            pwlb_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = w_is_add ? pwlb_pkg::S_DONE : pwlb_pkg::S_SRCH;
                end
            end
            pwlb_pkg::S_SRCH: begin
                n_state = w_pair ? pwlb_pkg::S_DIV : pwlb_pkg::S_DONE;
            end
            pwlb_pkg::S_DIV: begin
                if (w_div_done) begin
                    n_state = pwlb_pkg::S_DONE;
                end
            end
            pwlb_pkg::S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_state = pwlb_pkg::S_IDLE;
                end
            end
            default: n_state = pwlb_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        w_in_ready  = 1'b0;
        w_div_start = 1'b0;
        w_out_load  = 1'b0;
        case (r_state)
            pwlb_pkg::S_IDLE: w_in_ready  = 1'b1;
            pwlb_pkg::S_SRCH: w_div_start = w_pair;
            pwlb_pkg::S_DIV:  w_in_ready  = 1'b0;
            pwlb_pkg::S_DONE: w_out_load  = !r_out_valid || o_rsp.ready;
            default:          w_in_ready  = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pwlb_pkg::S_IDLE;
            r_count     <= '0;
            r_axis_min  <= '0;
            r_axis_max  <= pwlb_pkg::AXIS_MAX_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_ins.ins) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cfg.valid) begin
                case (i_cfg.reg_index)
                    pwlb_pkg::REG_AXIS_MIN: r_axis_min <= i_cfg.wdata;
                    pwlb_pkg::REG_AXIS_MAX: r_axis_max <= i_cfg.wdata;
                    default: ;
                endcase
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x      <= w_clamp;
            r_first  <= '0;
            r_second <= '0;
            r_alpha  <= '0;
            if (!w_is_add) begin
                r_st <= pwlb_pkg::ST_OK;
            end else if (i_req.anim_id == '0) begin
                r_st <= pwlb_pkg::ST_NULL;
            end else if (w_full) begin
                r_st <= pwlb_pkg::ST_FULL;
            end else begin
                r_st <= pwlb_pkg::ST_OK;
            end
        end else if (r_state == pwlb_pkg::S_SRCH) begin
            r_zero_span <= w_span == '0;
            if (w_empty) begin
                r_st <= pwlb_pkg::ST_EMPTY;
            end else if (w_at_first) begin
                r_first  <= w_first_pt.id;
                r_second <= w_first_pt.id;
            end else if (w_at_last) begin
                r_first  <= w_last_pt.id;
                r_second <= w_last_pt.id;
            end else begin
                r_first  <= w_a.id;
                r_second <= w_b.id;
            end
        end else if ((r_state == pwlb_pkg::S_DIV) && w_div_done) begin
            r_alpha <= r_zero_span ? '0 : w_quot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_o_status <= r_st;
            r_o_first  <= r_first;
            r_o_second <= r_second;
            r_o_alpha  <= r_alpha;
        end
    end

    assign i_req.ready     = w_in_ready;
    assign i_cfg.ready     = 1'b1;
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.status    = r_o_status;
    assign o_rsp.first_id  = r_o_first;
    assign o_rsp.second_id = r_o_second;
    assign o_rsp.alpha     = r_o_alpha;

    `PWLB_ASSERT_NOW(a_ins_not_full, i_clk, i_rst_n, w_ins.ins, r_count < pwlb_pkg::CNT_W'(pwlb_pkg::MAX_POINTS))
    `PWLB_ASSERT_NEXT(a_count_step, i_clk, i_rst_n, w_ins.ins, r_count == $past(r_count) + 1'b1)
    `PWLB_ASSERT_NOW(a_div_in_div, i_clk, i_rst_n, w_div_done, r_state == pwlb_pkg::S_DIV)
    `PWLB_ASSERT_NOW(a_alpha_range, i_clk, i_rst_n, r_state == pwlb_pkg::S_DONE, r_alpha <= pwlb_pkg::ALPHA_ONE)

endmodule
